FILE: hdl/bpa_pkg.sv
// Shared types, codes and constants for the bitmap page allocator.
package bpa_pkg;

   localparam int MAP_PAGES_DEF = 4096;
   localparam int PAGE_BITS_DEF = 12;
   localparam int ADDR_BITS_DEF = 32;

   localparam int FIELD_W      = 32;
   localparam int FUNC_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int FIRST_PAGE_W = 20;
   localparam int END_PAGE_W   = 21;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 21;
   localparam int REQ_DATA_W   = 128;
   localparam int RSP_DATA_W   = 40;

   localparam logic [END_PAGE_W-1:0] END_PAGE_RST = END_PAGE_W'(4096);

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PAGE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_PAGE   = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FN_RESERVE = 2'd0,
      FN_FREE    = 2'd1,
      FN_ALLOC   = 2'd2,
      FN_INVALID = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_REJECT   = 2'd1,
      STAT_NO_SPACE = 2'd2,
      STAT_BAD      = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_CLR,
      CMD_LOAD,
      CMD_PREP1,
      CMD_PREP2,
      CMD_PREP3,
      CMD_PREP4,
      CMD_RSV_INIT,
      CMD_FREE_INIT,
      CMD_SCAN_INIT,
      CMD_J_INC,
      CMD_ALIGN,
      CMD_RUN_END,
      CMD_SKIP,
      CMD_RESTART,
      CMD_REPASS,
      CMD_FIN1,
      CMD_FIN2,
      CMD_FIN3,
      CMD_FIN4,
      CMD_FIN5,
      CMD_WR_ONE,
      CMD_WR_ZERO,
      CMD_POST
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type op;
      status_type status;
   } dp_ctrl_type;

   typedef struct packed {
      func_type func;
      logic     rsv_bad;
      logic     free_bad;
      logic     alloc_bad;
      logic     j_ge_n;
      logic     j_ge_end;
      logic     j_eq_end;
      logic     map_bit;
      logic     pref_le_offs;
      logic     clr_last;
   } dp_stat_type;

endpackage

FILE: hdl/bpa_dp.sv
// Datapath of the page allocator: request registers, page map memory and scan arithmetic.
module bpa_dp #(
   parameter int MAP_PAGES = bpa_pkg::MAP_PAGES_DEF,
   parameter int PAGE_BITS = bpa_pkg::PAGE_BITS_DEF,
   parameter int ADDR_BITS = bpa_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bpa_pkg::dp_ctrl_type            ctrl,
   output bpa_pkg::dp_stat_type            stat,
   input  logic [bpa_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [bpa_pkg::FUNC_W-1:0]      req_tuser,
   input  logic                            csr_we,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bpa_pkg::status_type             rsp_status,
   output logic [bpa_pkg::FIELD_W-1:0]     rsp_addr
);
   import bpa_pkg::*;

   localparam int AW = $clog2(MAP_PAGES);
   localparam int NW = AW + 1;
   localparam int WW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + PAGE_BITS + 4;
   localparam int PW = WW - PAGE_BITS + 1;
   localparam logic [WW-1:0] PG_MASK = {{(WW-PAGE_BITS){1'b0}}, {PAGE_BITS{1'b1}}};
   localparam logic [WW-1:0] ADDR_MASK = {{(WW-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
   localparam logic [PAGE_BITS:0] PG_SIZE = {1'b1, {PAGE_BITS{1'b0}}};
   localparam logic [PW-1:0] CLR_LAST = PW'(MAP_PAGES - 1);

   logic map_mem [MAP_PAGES];
   logic rd_bit_ff;

   func_type             func_ff;
   logic [FIELD_W-1:0]   a_ff, s_ff, al_ff, g_ff;
   logic [FIRST_PAGE_W-1:0] first_page_ff;
   logic [END_PAGE_W-1:0]   end_page_ff;
   logic [NW-1:0]        n_ff;
   logic [NW-1:0]        n_in;
   logic [END_PAGE_W:0]  diff;

   logic [WW-1:0] sum_ff, gdiff_ff, bm_ff, pref_byte_ff, page_part_ff, ret_ff;
   logic          a_lt_base_ff, goal_ok_ff, alloc_bad_ff;
   logic [FIELD_W-1:0] alg_ff, alg_m1_ff, rem2_ff;
   logic [PW-1:0] area_ff, a_up_ff;
   logic [PW-1:0] rsv_sidx_ff, rsv_eidx_ff, rsv_end_ff, free_eidx_ff, free_sidx_ff;
   logic [PW-1:0] offs_ff, incr_ff, incr_m1_ff, pref_up_ff, pref_ff, cnt_ff;
   logic          rsv_bad_ff, free_bad_ff, tail_ok_ff, fits_ff;
   logic [PAGE_BITS:0] off_ff, rem_ff;
   logic [PW-1:0] i_ff, j_ff, end_ff;
   logic [ADDR_BITS-1:0] ls_ff;
   logic [AW-1:0]        last_page_ff;
   logic [PAGE_BITS-1:0] last_fill_ff;
   status_type           rsp_status_ff;
   logic [FIELD_W-1:0]   rsp_addr_ff;

   logic [WW-1:0] base, end_w, a_w, s_w, g_w, alg_m1_w, bmod;
   logic          mem_we, mem_wbit;

   always_comb begin
      base     = WW'(first_page_ff) << PAGE_BITS;
      end_w    = WW'(end_page_ff);
      a_w      = WW'(a_ff);
      s_w      = WW'(s_ff);
      g_w      = WW'(g_ff);
      alg_m1_w = WW'(alg_m1_ff);
      bmod     = base & alg_m1_w;
      diff     = {1'b0, end_page_ff} - (END_PAGE_W+1)'(first_page_ff);
      if (end_page_ff <= END_PAGE_W'(first_page_ff)) begin
         n_in = '0;
      end else if (diff > (END_PAGE_W+1)'(MAP_PAGES)) begin
         n_in = NW'(MAP_PAGES);
      end else begin
         n_in = NW'(diff);
      end
      mem_we   = (ctrl.op == CMD_CLR) || (ctrl.op == CMD_WR_ONE) || (ctrl.op == CMD_WR_ZERO);
      mem_wbit = (ctrl.op != CMD_WR_ZERO);
   end

   always_comb begin
      stat.func         = func_ff;
      stat.rsv_bad      = rsv_bad_ff;
      stat.free_bad     = free_bad_ff;
      stat.alloc_bad    = alloc_bad_ff;
      stat.j_ge_n       = (WW'(j_ff) >= WW'(n_ff));
      stat.j_ge_end     = (j_ff >= end_ff);
      stat.j_eq_end     = (j_ff == end_ff);
      stat.map_bit      = rd_bit_ff;
      stat.pref_le_offs = (pref_ff <= offs_ff);
      stat.clr_last     = (j_ff == CLR_LAST);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[j_ff[AW-1:0]] <= mem_wbit;
      end
      rd_bit_ff <= map_mem[j_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
         end_page_ff   <= END_PAGE_RST;
         n_ff          <= '0;
         j_ff          <= '0;
         ls_ff         <= '0;
         last_page_ff  <= '0;
         last_fill_ff  <= '0;
      end else begin
         n_ff <= n_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_PAGE: first_page_ff <= csr_wdata[FIRST_PAGE_W-1:0];
               CSR_END_PAGE:   end_page_ff   <= csr_wdata[END_PAGE_W-1:0];
               default: ;
            endcase
         end
         case (ctrl.op)
            CMD_CLR:       j_ff <= j_ff + 1'b1;
            CMD_RSV_INIT:  j_ff <= rsv_sidx_ff;
            CMD_FREE_INIT: begin
               j_ff <= free_sidx_ff;
               if (a_w < WW'(ls_ff)) begin
                  ls_ff <= ADDR_BITS'(a_w);
               end
            end
            CMD_SCAN_INIT: j_ff <= pref_ff;
            CMD_J_INC:     j_ff <= j_ff + 1'b1;
            CMD_ALIGN:     j_ff <= (j_ff + incr_m1_ff) & ~incr_m1_ff;
            CMD_SKIP:      j_ff <= i_ff + incr_ff;
            CMD_RESTART:   j_ff <= ((j_ff + incr_m1_ff) | incr_m1_ff) + 1'b1;
            CMD_REPASS:    j_ff <= offs_ff;
            CMD_FIN1:      ls_ff <= ADDR_BITS'(WW'(i_ff) << PAGE_BITS);
            CMD_FIN4: begin
               if (tail_ok_ff) begin
                  if (fits_ff) begin
                     last_fill_ff <= PAGE_BITS'(WW'(off_ff) + s_w);
                  end else begin
                     last_fill_ff <= rem2_ff[PAGE_BITS-1:0];
                  end
               end else begin
                  last_fill_ff <= s_ff[PAGE_BITS-1:0];
               end
            end
            CMD_FIN5: begin
               j_ff <= i_ff;
               if (!(tail_ok_ff && fits_ff)) begin
                  last_page_ff <= AW'(i_ff + cnt_ff - 1'b1);
               end
            end
            CMD_WR_ONE:    j_ff <= j_ff + 1'b1;
            CMD_WR_ZERO:   j_ff <= j_ff + 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.op)
         CMD_LOAD: begin
            func_ff <= func_type'(req_tuser);
            a_ff    <= req_tdata[31:0];
            s_ff    <= req_tdata[63:32];
            al_ff   <= req_tdata[95:64];
            g_ff    <= req_tdata[127:96];
         end
         CMD_PREP1: begin
            sum_ff       <= a_w + s_w;
            a_lt_base_ff <= a_w < base;
            goal_ok_ff   <= (g_ff != '0) && (g_w >= base)
                            && ((g_w >> PAGE_BITS) < end_w);
            alloc_bad_ff <= (s_ff == '0) || ((al_ff & (al_ff - 1'b1)) != '0);
            alg_ff       <= (al_ff == '0) ? FIELD_W'(1) : al_ff;
            alg_m1_ff    <= (al_ff == '0) ? '0 : al_ff - 1'b1;
            area_ff      <= PW'((s_w + PG_MASK) >> PAGE_BITS);
            gdiff_ff     <= g_w - base;
            bm_ff        <= PG_MASK - base;
            a_up_ff      <= PW'((a_w + PG_MASK) >> PAGE_BITS);
         end
         CMD_PREP2: begin
            rsv_sidx_ff  <= PW'((a_w - base) >> PAGE_BITS);
            rsv_eidx_ff  <= PW'((sum_ff + bm_ff) >> PAGE_BITS);
            rsv_end_ff   <= PW'((sum_ff + PG_MASK) >> PAGE_BITS);
            free_eidx_ff <= PW'((sum_ff - base) >> PAGE_BITS);
            free_sidx_ff <= a_up_ff - PW'(first_page_ff);
            if (!goal_ok_ff) begin
               pref_byte_ff <= '0;
            end else if (WW'(ls_ff) >= gdiff_ff) begin
               pref_byte_ff <= WW'(ls_ff);
            end else begin
               pref_byte_ff <= gdiff_ff;
            end
            offs_ff    <= (bmod != '0) ? PW'((WW'(alg_ff) - bmod) >> PAGE_BITS) : '0;
            incr_ff    <= ((alg_ff >> PAGE_BITS) == '0) ? PW'(1) : PW'(alg_ff >> PAGE_BITS);
            incr_m1_ff <= ((alg_ff >> PAGE_BITS) == '0) ? '0 : PW'(alg_m1_ff >> PAGE_BITS);
         end
         CMD_PREP3: begin
            rsv_bad_ff <= (s_ff == '0) || a_lt_base_ff || (rsv_sidx_ff >= rsv_eidx_ff)
                          || ((a_w >> PAGE_BITS) >= end_w) || (WW'(rsv_end_ff) > end_w)
                          || (WW'(rsv_eidx_ff) > WW'(n_ff));
            free_bad_ff <= ((sum_ff >> PAGE_BITS) > end_w) || a_lt_base_ff
                           || (WW'(free_eidx_ff) > WW'(n_ff));
            pref_up_ff <= PW'(((pref_byte_ff + alg_m1_w) & ~alg_m1_w) >> PAGE_BITS);
         end
         CMD_PREP4:     pref_ff <= pref_up_ff + offs_ff;
         CMD_RSV_INIT:  end_ff  <= rsv_eidx_ff;
         CMD_FREE_INIT: end_ff  <= free_eidx_ff;
         CMD_SCAN_INIT: i_ff    <= pref_ff;
         CMD_ALIGN:     i_ff    <= (j_ff + incr_m1_ff) & ~incr_m1_ff;
         CMD_RUN_END:   end_ff  <= i_ff + area_ff;
         CMD_SKIP:      i_ff    <= i_ff + incr_ff;
         CMD_RESTART:   i_ff    <= ((j_ff + incr_m1_ff) | incr_m1_ff) + 1'b1;
         CMD_REPASS: begin
            i_ff    <= offs_ff;
            pref_ff <= offs_ff;
         end
         CMD_FIN1: begin
            tail_ok_ff <= (alg_ff < FIELD_W'(PG_SIZE)) && (last_fill_ff != '0)
                          && ((PW'(last_page_ff) + 1'b1) == i_ff);
            off_ff <= ((PAGE_BITS+1)'(last_fill_ff) + alg_m1_ff[PAGE_BITS:0])
                      & ~alg_m1_ff[PAGE_BITS:0];
         end
         CMD_FIN2: begin
            rem_ff <= PG_SIZE - off_ff;
            if (tail_ok_ff) begin
               page_part_ff <= (WW'(last_page_ff) << PAGE_BITS) + WW'(off_ff);
            end else begin
               page_part_ff <= WW'(i_ff) << PAGE_BITS;
            end
         end
         CMD_FIN3: begin
            fits_ff <= s_ff < FIELD_W'(rem_ff);
            rem2_ff <= s_ff - FIELD_W'(rem_ff);
            ret_ff  <= page_part_ff + base;
         end
         CMD_FIN4: begin
            if (!tail_ok_ff) begin
               cnt_ff <= area_ff;
            end else if (fits_ff) begin
               cnt_ff <= '0;
            end else begin
               cnt_ff <= PW'((WW'(rem2_ff) + PG_MASK) >> PAGE_BITS);
            end
         end
         CMD_FIN5:      end_ff <= i_ff + cnt_ff;
         CMD_POST: begin
            rsp_status_ff <= ctrl.status;
            if ((ctrl.status == STAT_OK) && (func_ff == FN_ALLOC)) begin
               rsp_addr_ff <= FIELD_W'(ret_ff & ADDR_MASK);
            end else begin
               rsp_addr_ff <= '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_addr   = rsp_addr_ff;

endmodule

FILE: hdl/bpa_ctrl.sv
// Sequencer of the page allocator: request handshake, map sweep and scan control.
module bpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  bpa_pkg::dp_stat_type stat,
   output bpa_pkg::dp_ctrl_type ctrl
);
   import bpa_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_PREP1, S_PREP2, S_PREP3, S_PREP4, S_DISPATCH,
      S_FILL, S_FREE_RD, S_FREE_CHK, S_SEEK_RD, S_SEEK_CHK, S_ALN_RD,
      S_ALN_CHK, S_RUN_RD, S_RUN_CHK, S_PASS_END,
      S_FIN1, S_FIN2, S_FIN3, S_FIN4, S_FIN5, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   dp_cmd_type op;
   logic       post;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      op        = CMD_NOP;
      post      = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            op = CMD_CLR;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op       = CMD_LOAD;
               state_in = S_PREP1;
            end
         end
         S_PREP1: begin
            op       = CMD_PREP1;
            state_in = S_PREP2;
         end
         S_PREP2: begin
            op       = CMD_PREP2;
            state_in = S_PREP3;
         end
         S_PREP3: begin
            op       = CMD_PREP3;
            state_in = S_PREP4;
         end
         S_PREP4: begin
            op       = CMD_PREP4;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            status_in = STAT_OK;
            case (stat.func)
               FN_RESERVE: begin
                  if (stat.rsv_bad) begin
                     status_in = STAT_REJECT;
                     state_in  = S_DONE;
                  end else begin
                     op       = CMD_RSV_INIT;
                     state_in = S_FILL;
                  end
               end
               FN_FREE: begin
                  if (stat.free_bad) begin
                     status_in = STAT_REJECT;
                     state_in  = S_DONE;
                  end else begin
                     op       = CMD_FREE_INIT;
                     state_in = S_FREE_RD;
                  end
               end
               FN_ALLOC: begin
                  if (stat.alloc_bad) begin
                     status_in = STAT_BAD;
                     state_in  = S_DONE;
                  end else begin
                     op       = CMD_SCAN_INIT;
                     state_in = S_SEEK_RD;
                  end
               end
               default: begin
                  status_in = STAT_BAD;
                  state_in  = S_DONE;
               end
            endcase
         end
         S_FILL: begin
            if (stat.j_ge_end) begin
               state_in = S_DONE;
            end else begin
               op = CMD_WR_ONE;
            end
         end
         S_FREE_RD: begin
            state_in = stat.j_ge_end ? S_DONE : S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (!stat.map_bit) begin
               status_in = STAT_REJECT;
               state_in  = S_DONE;
            end else begin
               op       = CMD_WR_ZERO;
               state_in = S_FREE_RD;
            end
         end
         S_SEEK_RD: begin
            state_in = stat.j_ge_n ? S_PASS_END : S_SEEK_CHK;
         end
         S_SEEK_CHK: begin
            if (stat.map_bit) begin
               op       = CMD_J_INC;
               state_in = S_SEEK_RD;
            end else begin
               op       = CMD_ALIGN;
               state_in = S_ALN_RD;
            end
         end
         S_ALN_RD: begin
            op       = CMD_RUN_END;
            state_in = stat.j_ge_n ? S_PASS_END : S_ALN_CHK;
         end
         S_ALN_CHK: begin
            if (stat.map_bit) begin
               op       = CMD_SKIP;
               state_in = S_SEEK_RD;
            end else begin
               state_in = S_RUN_RD;
            end
         end
         S_RUN_RD: begin
            if (stat.j_eq_end) begin
               state_in = S_FIN1;
            end else if (stat.j_ge_n) begin
               op       = CMD_RESTART;
               state_in = S_SEEK_RD;
            end else begin
               state_in = S_RUN_CHK;
            end
         end
         S_RUN_CHK: begin
            if (stat.map_bit) begin
               op       = CMD_RESTART;
               state_in = S_SEEK_RD;
            end else begin
               op       = CMD_J_INC;
               state_in = S_RUN_RD;
            end
         end
         S_PASS_END: begin
            if (stat.pref_le_offs) begin
               status_in = STAT_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               op       = CMD_REPASS;
               state_in = S_SEEK_RD;
            end
         end
         S_FIN1: begin
            op       = CMD_FIN1;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            op       = CMD_FIN2;
            state_in = S_FIN3;
         end
         S_FIN3: begin
            op       = CMD_FIN3;
            state_in = S_FIN4;
         end
         S_FIN4: begin
            op       = CMD_FIN4;
            state_in = S_FIN5;
         end
         S_FIN5: begin
            op       = CMD_FIN5;
            state_in = S_FILL;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               op       = CMD_POST;
               post     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         status_ff    <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign ctrl.op     = op;
   assign ctrl.status = status_ff;
   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;

endmodule

FILE: hdl/bitmap_page_allocator_top.sv
// Steps: setup in LOAD, PREP1 to PREP4 and DISPATCH; reserve then marks each page, free
// reads and clears each page, allocate reads and checks each page probed, runs FIN1 to
// FIN5 and marks each page; one request at a time, map memory single port. A new request
// waits for the last result to post; a result waits in the output register. Reset:
// synchronous; a sweep marks every page reserved before req_tready rises; first_page
// resets to 0, end_page to 4096. Top level of the bitmap page allocator.
module bitmap_page_allocator_top #(
   parameter int MAP_PAGES = bpa_pkg::MAP_PAGES_DEF,
   parameter int PAGE_BITS = bpa_pkg::PAGE_BITS_DEF,
   parameter int ADDR_BITS = bpa_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bpa_pkg::REQ_DATA_W-1:0]  req_tdata,  // addr, size, align, goal
   input  logic [bpa_pkg::FUNC_W-1:0]      req_tuser,  // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bpa_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // status, alloc_addr
   input  logic                            csr_we,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bpa_pkg::*;

   dp_ctrl_type        ctrl;
   dp_stat_type        stat;
   status_type         rsp_status;
   logic [FIELD_W-1:0] rsp_addr;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   bpa_dp #(
      .MAP_PAGES (MAP_PAGES),
      .PAGE_BITS (PAGE_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_status (rsp_status),
      .rsp_addr   (rsp_addr)
   );

   assign rsp_tdata = {{(RSP_DATA_W-FIELD_W-STATUS_W){1'b0}}, rsp_addr, rsp_status};

endmodule

FILE: bench/tb.sv
// Self-checking bench for the bitmap page allocator: predicts every result and compares.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int NPAGES = 4096;
   localparam int PBITS = 12;
   localparam longint PSIZE = 64'd1 << PBITS;
   localparam longint PMASK = PSIZE - 1;
   localparam longint AMASK = 64'hFFFF_FFFF;
   localparam longint CYCLE_LIMIT = 64'd100_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bitmap_page_allocator_top DUT (.*);

   always #10 clock = ~clock;

   typedef struct {
      status_type status;
      logic [31:0] addr;
   } outcome_type;

   bit page_used[NPAGES];
   longint last_ok, last_pg, last_fill, first_pg, end_pg;
   outcome_type outcome_q[$];
   int errors = 0;
   int n_sent = 0, n_checked = 0, n_alloc_ok = 0;
   longint cycles = 0;
   bit send_gaps = 1'b1, recv_gaps = 1'b1;
   int hold_cycles = 0;
   int op_count[4];

   function automatic longint region_pages();
      longint n;
      if (end_pg <= first_pg) return 0;
      n = end_pg - first_pg;
      return n > NPAGES ? NPAGES : n;
   endfunction

   function automatic bit page_busy(longint i, longint n);
      return i >= n || page_used[i];
   endfunction

   function automatic longint roundup(longint v, longint a);
      return (v + a - 1) & ~(a - 1);
   endfunction

   function automatic status_type reserve_pages(longint a, longint s);
      longint base, sidx, eidx, e;
      base = first_pg << PBITS;
      if (s == 0 || a < base) return STAT_REJECT;
      sidx = (a - base) >> PBITS;
      eidx = (a + s - base + PMASK) >> PBITS;
      e = (a + s + PMASK) >> PBITS;
      if (sidx >= eidx || (a >> PBITS) >= end_pg || e > end_pg || eidx > region_pages())
         return STAT_REJECT;
      for (longint i = sidx; i < eidx; i++) page_used[i] = 1'b1;
      return STAT_OK;
   endfunction

   function automatic status_type release_pages(longint a, longint s);
      longint base, sidx, eidx;
      base = first_pg << PBITS;
      if (((a + s) >> PBITS) > end_pg || a < base) return STAT_REJECT;
      eidx = (a + s - base) >> PBITS;
      if (eidx > region_pages()) return STAT_REJECT;
      if (a < last_ok) last_ok = a;
      sidx = ((a + PMASK) >> PBITS) - first_pg;
      for (longint i = sidx; i < eidx; i++) begin
         if (!page_used[i]) return STAT_REJECT;
         page_used[i] = 1'b0;
      end
      return STAT_OK;
   endfunction

   function automatic status_type place_block(longint s, longint al, longint g,
                                              output longint where);
      longint base, n, offs, pref, area, incr, i, j, start, off, rem, ret;
      bit found;
      base = first_pg << PBITS;
      n = region_pages();
      offs = 0;
      found = 1'b0;
      i = 0;
      where = 0;
      if (s == 0 || (al & (al - 1)) != 0) return STAT_BAD;
      if (al == 0) al = 1;
      if ((base & (al - 1)) != 0) offs = al - (base & (al - 1));
      offs = offs >> PBITS;
      if (g != 0 && g >= base && (g >> PBITS) < end_pg) begin
         pref = g - base;
         if (last_ok >= pref) pref = last_ok;
      end else begin
         pref = 0;
      end
      pref = (roundup(pref, al) >> PBITS) + offs;
      area = (s + PMASK) >> PBITS;
      incr = al >> PBITS;
      if (incr == 0) incr = 1;
      forever begin
         i = pref;
         while (i < n) begin
            j = i;
            while (j < n && page_used[j]) j++;
            i = roundup(j, incr);
            if (page_busy(i, n)) begin
               i += incr;
               continue;
            end
            j = i;
            while (j < i + area && !page_busy(j, n)) j++;
            if (j == i + area) begin
               found = 1'b1;
               break;
            end
            i = roundup(j, incr) + incr;
         end
         if (found || pref <= offs) break;
         pref = offs;
      end
      if (!found) return STAT_NO_SPACE;
      start = i;
      last_ok = (start << PBITS) & AMASK;
      if (al < PSIZE && last_fill != 0 && last_pg + 1 == start) begin
         off = roundup(last_fill, al);
         rem = PSIZE - off;
         ret = last_pg * PSIZE + off + base;
         if (s < rem) begin
            area = 0;
            last_fill = off + s;
         end else begin
            rem = s - rem;
            area = (rem + PMASK) >> PBITS;
            last_pg = start + area - 1;
            last_fill = rem;
         end
         last_fill &= PMASK;
      end else begin
         last_pg = start + area - 1;
         last_fill = s & PMASK;
         ret = start * PSIZE + base;
      end
      for (j = start; j < start + area; j++) page_used[j] = 1'b1;
      where = ret & AMASK;
      return STAT_OK;
   endfunction

   task automatic send_request(func_type fn, logic [31:0] a, logic [31:0] s,
                               logic [31:0] al, logic [31:0] g);
      outcome_type o;
      longint w;
      w = 0;
      while (send_gaps && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {g, al, s, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (fn)
         FN_RESERVE: o.status = reserve_pages(a, s);
         FN_FREE:    o.status = release_pages(a, s);
         FN_ALLOC:   o.status = place_block(s, al, g, w);
         default:    o.status = STAT_BAD;
      endcase
      o.addr = (o.status == STAT_OK) ? w[31:0] : 32'd0;
      if (fn == FN_ALLOC && o.status == STAT_OK) n_alloc_ok++;
      op_count[fn]++;
      outcome_q.push_back(o);
      n_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, longint v);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FIRST_PAGE) first_pg = v & 64'hFFFFF;
      else end_pg = v & 64'h1FFFFF;
   endtask

   function automatic logic [31:0] rand_align();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return $urandom;
         default: return 32'd1 << $urandom_range(16);
      endcase
   endfunction

   function automatic logic [31:0] region_addr();
      longint b;
      b = (first_pg << PBITS) + ($urandom_range(region_pages() + 2) << PBITS);
      if ($urandom_range(1)) b += $urandom_range(PMASK);
      return b[31:0];
   endfunction

   function automatic logic [31:0] rand_size();
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(PMASK);
         2: return 32'd0;
         default: return $urandom_range(8 * PSIZE);
      endcase
   endfunction

   task automatic send_random(int count);
      logic [31:0] a;
      for (int k = 0; k < count; k++) begin
         a = ($urandom_range(9) == 0) ? $urandom : region_addr();
         case ($urandom_range(9))
            0, 1:    send_request(FN_RESERVE, a, rand_size(), $urandom, $urandom);
            2, 3, 4: send_request(FN_FREE, a, rand_size(), $urandom, $urandom);
            9:       send_request(func_type'($urandom_range(3)), $urandom, $urandom,
                                  $urandom, $urandom);
            default: send_request(FN_ALLOC, $urandom, rand_size(), rand_align(),
                                  ($urandom_range(2) == 0) ? 32'd0 : region_addr());
         endcase
      end
   endtask

   task automatic test_directed();
      send_request(FN_ALLOC, 0, 100, 0, 0);
      send_request(FN_FREE, 0, 32'h0100_0000, 0, 0);
      send_request(FN_FREE, 32'h0000_3000, 32'h2000, 0, 0);
      send_request(FN_FREE, 32'h0000_3800, 32'h1000, 0, 0);
      send_request(FN_FREE, 32'h0000_1000, 32'h0040_0000, 0, 0);
      send_request(FN_FREE, 32'h0000_2000, 32'h1000, 0, 0);
      send_request(FN_ALLOC, 0, 0, 0, 0);
      send_request(FN_ALLOC, 0, 100, 3, 0);
      send_request(FN_ALLOC, 0, 100, 0, 0);
      send_request(FN_ALLOC, 0, 200, 8, 0);
      send_request(FN_ALLOC, 0, 32'h1F00, 0, 0);
      send_request(FN_ALLOC, 0, 32'h3000, 32'h4000, 32'h0010_0000);
      send_request(FN_ALLOC, 0, 32'h1000, 32'h8000_0000, 0);
      send_request(FN_ALLOC, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      send_request(FN_RESERVE, 32'h0000_5001, 32'h10, 0, 0);
      send_request(FN_RESERVE, 32'h0000_5000, 0, 0, 0);
      send_request(FN_RESERVE, 32'hFFFF_F000, 32'h2000, 0, 0);
      send_request(FN_RESERVE, 32'h00FF_F000, 32'h1000, 0, 0);
      send_request(FN_INVALID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FN_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
   endtask

   task automatic test_region(longint fp, longint ep, int count);
      write_csr(CSR_FIRST_PAGE, fp);
      write_csr(CSR_END_PAGE, ep);
      send_request(FN_FREE, 32'(fp << PBITS), 32'h0100_0000, 0, 0);
      send_random(count);
   endtask

   task automatic test_backpressure();
      send_gaps = 1'b0;
      hold_cycles = 400;
      send_random(20);
      drain();
      recv_gaps = 1'b0;
      send_random(60);
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(recv_gaps && $urandom_range(99) < 24);
      end
   end

   always @(posedge clock) begin
      outcome_type o;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            o = outcome_q.pop_front();
            n_checked++;
            if (rsp_tdata[1:0] !== o.status) begin
               $error("status expected %0d actual %0d", o.status, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[33:2] !== o.addr) begin
               $error("alloc_addr expected %h actual %h", o.addr, rsp_tdata[33:2]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NPAGES; i++) page_used[i] = 1'b1;
      last_ok = 0;
      last_pg = 0;
      last_fill = 0;
      first_pg = 0;
      end_pg = 4096;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      send_random(150);
      test_backpressure();
      test_region(16, 1040, 120);
      test_region(1048575, 1048576, 40);
      test_region(1000, 1048576, 120);
      test_region(300, 200, 30);
      test_region(0, 0, 20);
      test_region(0, 4096, 150);
      drain();
      repeat (200) @(posedge clock);
      $display("tb: %0d requests (%0d reserve, %0d free, %0d alloc, %0d invalid), %0d checked",
               n_sent, op_count[0], op_count[1], op_count[2], op_count[3], n_checked);
      $display("tb: %0d successful allocations over six region settings", n_alloc_ok);
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
